/* sv/srht_pkg.sv */
// Shared types and codes for the swap-remove handle table.
package srht_pkg;

   // Request kinds carried in a request word
   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_POP    = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   // Result status codes; the fourth code is never produced
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_CLEAR,
      S_POP_CHK,
      S_POP_GET,
      S_SCAN,
      S_MOVE
   } state_type;

   // Request word
   typedef struct packed {
      req_kind_type req_type;
      logic [31:0]  handle;
      logic [7:0]   position;
   } req_word_type;

   // Result word
   typedef struct packed {
      status_type  status;
      logic [31:0] out_handle;
      logic [7:0]  out_position;
      logic [8:0]  live_count;
   } rsp_word_type;

endpackage

/* sv/srht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module srht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/swap_remove_handle_table_core.sv */
// Top level of the swap-remove handle table: request control and entry store.
//
// Usage: requests arrive on the req_ channel (valid/stall), one word per
// request: add a handle, pop by index, remove by value, or clear. Every
// request gives exactly one word on the rsp_ channel carrying the status,
// the popped handle, the index where remove found its handle, and the live
// count after the request.
// The block works on one request at a time; req_stall is high while one is
// in progress. Add and clear go straight to the result; pop reads the entry,
// reads the last entry, then writes it back into the hole; remove scans up to
// the first match and then moves the last entry the same way, or scans the
// whole live count when the handle is absent. The scan reads one entry a
// cycle through the single read port of the entry store.
// A new request is taken in the cycle after the result register is loaded.
// A result waiting under rsp_stall does not block acceptance of the next
// request; that request completes only once the result register is free,
// and until then its store write and count update are held back.
// Reset (synchronous, active high) empties the table and the result
// register; the entry store itself is not cleared, as only entries below
// the live count are ever used.
module swap_remove_handle_table_core
   import srht_pkg::*;
#(
   parameter int DEPTH        = 256,
   parameter int HANDLE_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;

   state_type state_ff, state_in;
   req_word_type req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic chk_ff, chk_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic [AW-1:0] hole_ff, hole_in;
   logic [HANDLE_WIDTH-1:0] got_ff, got_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic accept;
   logic slot_free;
   logic finish;
   logic finish_go;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [HANDLE_WIDTH-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [HANDLE_WIDTH-1:0] rd_data;
   logic [HANDLE_WIDTH-1:0] req_h;
   logic [AW-1:0] last_idx;
   logic pos_ok;
   logic full;
   logic match;
   logic more;
   logic [CW-1:0] count_next;
   status_type res_status;
   logic [31:0] res_handle;
   logic [7:0] res_pos;

   // Entry store
   srht_ram #(
      .WIDTH (HANDLE_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en && slot_free),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared conditions
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign finish_go = finish && slot_free;
   assign req_h     = HANDLE_WIDTH'(req_ff.handle);
   assign last_idx  = AW'(count_ff - CW'(1));
   assign pos_ok    = CMPW'(req_ff.position) < CMPW'(count_ff);
   assign full      = count_ff == CW'(DEPTH);
   assign match     = chk_ff && (rd_data == req_h);
   assign more      = issue_ff < count_ff;
   assign req_stall = state_ff != S_IDLE;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_word.req_type)
                  REQ_ADD:    state_in = S_ADD;
                  REQ_POP:    state_in = S_POP_CHK;
                  REQ_REMOVE: state_in = S_SCAN;
                  REQ_CLEAR:  state_in = S_CLEAR;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_ADD, S_CLEAR, S_MOVE: begin
            if (finish_go) state_in = S_IDLE;
         end
         S_POP_CHK: begin
            if (pos_ok) begin
               state_in = S_POP_GET;
            end else if (finish_go) begin
               state_in = S_IDLE;
            end
         end
         S_POP_GET: state_in = S_MOVE;
         S_SCAN: begin
            if (match) begin
               state_in = S_MOVE;
            end else if (!more && finish_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Store accesses, count and result per state
   always_comb begin
      rd_addr    = last_idx;
      wr_en      = 1'b0;
      wr_addr    = hole_ff;
      wr_data    = rd_data;
      finish     = 1'b0;
      res_status = ST_OK;
      res_handle = '0;
      res_pos    = '0;
      count_next = count_ff;
      case (state_ff)
         S_ADD: begin
            finish = 1'b1;
            if (full) begin
               res_status = ST_FULL;
            end else begin
               wr_en      = 1'b1;
               wr_addr    = AW'(count_ff);
               wr_data    = req_h;
               count_next = count_ff + CW'(1);
            end
         end
         S_CLEAR: begin
            finish     = 1'b1;
            count_next = '0;
         end
         S_POP_CHK: begin
            rd_addr = AW'(req_ff.position);
            if (!pos_ok) begin
               finish     = 1'b1;
               res_status = ST_NOT_FOUND;
            end
         end
         S_POP_GET: rd_addr = last_idx;
         S_SCAN: begin
            if (match) begin
               rd_addr = last_idx;
            end else if (more) begin
               rd_addr = AW'(issue_ff);
            end else begin
               finish     = 1'b1;
               res_status = ST_NOT_FOUND;
            end
         end
         S_MOVE: begin
            // Last entry sits on the read port; move it into the hole
            rd_addr    = last_idx;
            wr_en      = 1'b1;
            wr_addr    = hole_ff;
            wr_data    = rd_data;
            count_next = count_ff - CW'(1);
            finish     = 1'b1;
            if (req_ff.req_type == REQ_POP) begin
               res_handle = 32'(got_ff);
            end else begin
               res_pos = 8'(hole_ff);
            end
         end
         default: ;
      endcase
   end

   // Working registers
   always_comb begin
      req_in     = req_ff;
      count_in   = finish_go ? count_next : count_ff;
      issue_in   = issue_ff;
      chk_in     = chk_ff;
      chk_idx_in = chk_idx_ff;
      hole_in    = hole_ff;
      got_in     = got_ff;
      if (accept) begin
         req_in   = req_word;
         issue_in = '0;
         chk_in   = 1'b0;
      end
      if (state_ff == S_POP_GET) begin
         got_in  = rd_data;
         hole_in = AW'(req_ff.position);
      end
      if (state_ff == S_SCAN) begin
         // Issue the next read while comparing the previous one
         chk_in = 1'b0;
         if (match) begin
            hole_in = chk_idx_ff;
         end else if (more) begin
            issue_in   = issue_ff + CW'(1);
            chk_in     = 1'b1;
            chk_idx_in = AW'(issue_ff);
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (finish_go) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.status       = res_status;
         rsp_word_in.out_handle   = res_handle;
         rsp_word_in.out_position = res_pos;
         rsp_word_in.live_count   = 9'(count_next);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      issue_ff    <= issue_in;
      chk_idx_ff  <= chk_idx_in;
      hole_ff     <= hole_in;
      got_ff      <= got_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* sv/srht_checker.sv */
// Port-level checks for the swap-remove handle table, bound to the top level.
module srht_checker
   import srht_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // No result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word presented right after reset");

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // One request at a time: busy after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in progress");

   // The count never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_word.live_count) <= DEPTH)
      else $error("live count above capacity");

   // A full status only comes with a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_FULL |-> rsp_word.live_count == 9'(DEPTH))
      else $error("full status with table not full");

endmodule

bind swap_remove_handle_table_core srht_checker #(.DEPTH(DEPTH)) u_srht_checker (.*);

/* verif/tb.sv */
// Self-checking bench for the swap-remove handle table: directed plan, then random traffic.
module tb
   import srht_pkg::*;
();

   localparam int DEPTH        = 256;
   localparam int HANDLE_WIDTH = 32;
   localparam int RANDOM_ITEMS = 1220;
   localparam int LONG_HOLD    = 400;
   // ~1500 requests at worst a full scan, a long gap and a long stall each, then x4
   localparam int CYCLE_LIMIT  = 4000000;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_RANDOM,
      DRAIN_PERIODIC,
      DRAIN_HEAVY
   } drain_mode_type;

   // One row of the directed plan; the known result is used only where typed is set
   typedef struct packed {
      req_kind_type kind;
      logic [31:0]  handle;
      logic [7:0]   position;
      logic [8:0]   reps;
      logic         typed;
      rsp_word_type known;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // Shadow copy of the table
   logic [HANDLE_WIDTH-1:0] shadow_mem [DEPTH];
   int unsigned             shadow_count = 0;
   int unsigned             peak_count = 0;

   rsp_word_type   pending_rsp [$];
   int unsigned    words_sent = 0;
   int unsigned    results_seen = 0;
   int unsigned    failures = 0;
   int unsigned    status_tally [3] = '{0, 0, 0};
   int unsigned    burst_left = 0;
   int unsigned    cycle_count = 0;
   int unsigned    stall_hold = 0;
   int unsigned    pattern_left = 0;
   logic           long_hold_done = 1'b0;
   drain_mode_type drain_mode = DRAIN_FREE;

   // Directed plan: empty table, extremes, duplicates, zero handle, full table
   plan_row_type directed_plan [25] = '{
      '{REQ_POP,    32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_NOT_FOUND, 32'h0, 8'd0,   9'd0}},
      '{REQ_REMOVE, 32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_NOT_FOUND, 32'h0, 8'd0,   9'd0}},
      '{REQ_CLEAR,  32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_ADD,    32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd1}},
      '{REQ_ADD,    32'hFFFF_FFFF, 8'd255, 9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd2}},
      '{REQ_ADD,    32'h1234_5678, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd3}},
      '{REQ_ADD,    32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd4}},
      '{REQ_REMOVE, 32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd3}},
      '{REQ_REMOVE, 32'hDEAD_BEEF, 8'd0,   9'd1,   1'b1, '{ST_NOT_FOUND, 32'h0, 8'd0,   9'd3}},
      '{REQ_POP,    32'h0000_0000, 8'd255, 9'd1,   1'b1, '{ST_NOT_FOUND, 32'h0, 8'd0,   9'd3}},
      '{REQ_POP,    32'h0000_0000, 8'd3,   9'd1,   1'b1, '{ST_NOT_FOUND, 32'h0, 8'd0,   9'd3}},
      '{REQ_POP,    32'h0000_0000, 8'd2,   9'd1,   1'b0, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_POP,    32'h0000_0000, 8'd0,   9'd1,   1'b0, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_REMOVE, 32'hFFFF_FFFF, 8'd0,   9'd1,   1'b0, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_ADD,    32'h5555_5555, 8'd0,   9'd1,   1'b0, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_ADD,    32'hAAAA_AAAA, 8'd0,   9'd1,   1'b0, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_CLEAR,  32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_ADD,    32'hA500_0000, 8'd0,   9'd256, 1'b0, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_ADD,    32'h0000_0001, 8'd0,   9'd1,   1'b1, '{ST_FULL,      32'h0, 8'd0,   9'd256}},
      '{REQ_REMOVE, 32'hA500_00FF, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd255, 9'd255}},
      '{REQ_ADD,    32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd256}},
      '{REQ_ADD,    32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_FULL,      32'h0, 8'd0,   9'd256}},
      '{REQ_POP,    32'h0000_0000, 8'd255, 9'd1,   1'b0, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_POP,    32'h0000_0000, 8'd0,   9'd1,   1'b0, '{ST_OK,        32'h0, 8'd0,   9'd0}},
      '{REQ_CLEAR,  32'h0000_0000, 8'd0,   9'd1,   1'b1, '{ST_OK,        32'h0, 8'd0,   9'd0}}
   };

   swap_remove_handle_table_core #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one request to the shadow table and return the word it should produce
   function automatic rsp_word_type apply_request(req_word_type w);
      rsp_word_type            r;
      logic [HANDLE_WIDTH-1:0] h;
      int unsigned             hit;
      r = '0;
      r.status = ST_OK;
      h = w.handle[HANDLE_WIDTH-1:0];
      case (w.req_type)
         REQ_ADD: begin
            if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_mem[shadow_count] = h;
               shadow_count++;
            end
         end
         REQ_POP: begin
            if (w.position < shadow_count) begin
               r.out_handle = 32'(shadow_mem[w.position]);
               shadow_count--;
               shadow_mem[w.position] = shadow_mem[shadow_count];
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         REQ_REMOVE: begin
            // lowest-index match wins
            hit = shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
               if (hit == shadow_count && shadow_mem[i] == h) begin
                  hit = i;
               end
            end
            if (hit < shadow_count) begin
               shadow_count--;
               shadow_mem[hit] = shadow_mem[shadow_count];
               r.out_position = 8'(hit);
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      r.live_count = 9'(shadow_count);
      return r;
   endfunction

   // Offer one word, hold it until taken, then queue its result and maybe pause
   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type known);
      rsp_word_type predicted;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = apply_request(w);
      pending_rsp.push_back(typed ? known : predicted);
      words_sent++;
      if (shadow_count > peak_count) begin
         peak_count = shadow_count;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 4) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6)) begin
            @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Stimulus: directed plan, random episodes, then drain
   initial begin
      req_word_type w;
      int unsigned  random_sent;
      int unsigned  episode_left;
      int unsigned  roll;
      logic         filling;
      random_sent  = 0;
      episode_left = 0;
      filling      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed plan; repeated rows step the handle
      foreach (directed_plan[r]) begin
         for (int k = 0; k < directed_plan[r].reps; k++) begin
            w.req_type = directed_plan[r].kind;
            w.handle   = directed_plan[r].handle + 32'(k);
            w.position = directed_plan[r].position;
            send_word(w, directed_plan[r].typed, directed_plan[r].known);
         end
      end

      // random episodes: mostly mixed traffic, now and then a run to a full table
      while (random_sent < RANDOM_ITEMS) begin
         if (episode_left == 0) begin
            filling      = ($urandom_range(0, 9) == 0);
            episode_left = filling ? DEPTH + 64 : $urandom_range(20, 80);
         end
         episode_left--;
         w.handle   = $urandom();
         w.position = 8'($urandom());
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 94 : 45)) begin
            w.req_type = REQ_ADD;
         end else if (roll < (filling ? 96 : 67)) begin
            w.req_type = REQ_POP;
         end else if (roll < (filling ? 100 : 95)) begin
            w.req_type = REQ_REMOVE;
         end else begin
            w.req_type = REQ_CLEAR;
         end
         // small values collide; copies of live handles make duplicates and hits
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            w.handle = $urandom_range(0, 7);
         end else if (roll < 30) begin
            w.handle = roll[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
         end else if ((roll < 50 || (w.req_type == REQ_REMOVE && roll < 85))
                      && shadow_count != 0) begin
            w.handle = 32'(shadow_mem[$urandom_range(0, shadow_count - 1)]);
         end
         if (w.req_type == REQ_POP && shadow_count != 0 && $urandom_range(0, 9) < 8) begin
            w.position = 8'($urandom_range(0, shadow_count - 1));
         end
         send_word(w, 1'b0, '0);
         random_sent++;
      end

      // drop valid, wait for every result, then watch for strays
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DEPTH + 16) @(posedge clock);
      $display("covered %0d requests and %0d results, peak live count %0d",
               words_sent, results_seen, peak_count);
      $display("result mix: ok %0d, not found %0d, full %0d",
               status_tally[0], status_tally[1], status_tally[2]);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Receiver: free, random, periodic and heavy stall patterns, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         stall_hold   <= 0;
         pattern_left <= 0;
      end else if (stall_hold != 0) begin
         rsp_stall  <= 1'b1;
         stall_hold <= stall_hold - 1;
      end else if (!long_hold_done && results_seen >= 40) begin
         long_hold_done <= 1'b1;
         stall_hold     <= LONG_HOLD;
         rsp_stall      <= 1'b1;
      end else if (pattern_left == 0) begin
         drain_mode   <= drain_mode_type'($urandom_range(0, 3));
         pattern_left <= $urandom_range(16, 200);
         rsp_stall    <= 1'b0;
      end else begin
         pattern_left <= pattern_left - 1;
         case (drain_mode)
            DRAIN_FREE: begin
               rsp_stall <= 1'b0;
            end
            DRAIN_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 9) < 3);
            end
            DRAIN_PERIODIC: begin
               rsp_stall <= (pattern_left % 4) < 2;
            end
            default: begin
               if ($urandom_range(0, 63) == 0) begin
                  stall_hold <= $urandom_range(20, 120);
               end
               rsp_stall <= ($urandom_range(0, 9) < 6);
            end
         endcase
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (pending_rsp.size() == 0) begin
            $error("result word with no request outstanding");
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            status_tally[int'(want.status)]++;
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_word.status);
               failures++;
            end
            if (rsp_word.out_handle !== want.out_handle) begin
               $error("out_handle: expected %h actual %h", want.out_handle,
                      rsp_word.out_handle);
               failures++;
            end
            if (rsp_word.out_position !== want.out_position) begin
               $error("out_position: expected %0d actual %0d", want.out_position,
                      rsp_word.out_position);
               failures++;
            end
            if (rsp_word.live_count !== want.live_count) begin
               $error("live_count: expected %0d actual %0d", want.live_count,
                      rsp_word.live_count);
               failures++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
